// ===== hw/rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types, codes and defaults of the binary max-heap priority queue.
// ----------------------------------------------------------------------------
package mhpq_pkg;

   // default heap depth
   localparam int CAPACITY_DEF = 64;

   // fixed field widths
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int HELD_W   = 7;

   // opcode of an input word
   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // controller to datapath command codes
   localparam int CMD_W = 4;
   localparam logic [CMD_W-1:0] CMD_NONE    = 4'd0;
   localparam logic [CMD_W-1:0] CMD_INS     = 4'd1;
   localparam logic [CMD_W-1:0] CMD_FULL    = 4'd2;
   localparam logic [CMD_W-1:0] CMD_EMPTY   = 4'd3;
   localparam logic [CMD_W-1:0] CMD_RM      = 4'd4;
   localparam logic [CMD_W-1:0] CMD_RM_LOAD = 4'd5;
   localparam logic [CMD_W-1:0] CMD_RD_UP   = 4'd6;
   localparam logic [CMD_W-1:0] CMD_UP_MOVE = 4'd7;
   localparam logic [CMD_W-1:0] CMD_PUT     = 4'd8;
   localparam logic [CMD_W-1:0] CMD_RD_DN   = 4'd9;
   localparam logic [CMD_W-1:0] CMD_DN_MOVE = 4'd10;
   localparam logic [CMD_W-1:0] CMD_OUT     = 4'd11;

   typedef struct packed {
      logic [CMD_W-1:0] code;
   } cmd_type;

   typedef struct packed {
      logic full;       // heap holds CAPACITY entries
      logic empty;      // heap holds no entry
      logic count_one;  // heap holds exactly one entry
      logic pos_zero;   // hole sits at the root
      logic no_left;    // hole has no left child in the heap
      logic up_gt;      // held value beats its parent
      logic dn_move;    // a child beats the held value
   } sts_type;

endpackage

// ===== hw/rtl/mhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer of the heap: takes a word, steps the sift up or sift down a level
// per read and compare state pair and hands the result to the output register.
// ----------------------------------------------------------------------------
module mhpq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_opcode,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  mhpq_pkg::sts_type sts,
   output mhpq_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_UP_RD  = 3'd1;
   localparam logic [2:0] S_UP_CMP = 3'd2;
   localparam logic [2:0] S_RM_LD  = 3'd3;
   localparam logic [2:0] S_DN_RD  = 3'd4;
   localparam logic [2:0] S_DN_CMP = 3'd5;
   localparam logic [2:0] S_RESP   = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       valid_ff, valid_in;
   logic       accept;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = valid_ff;

   // next state and command
   always_comb begin
      state_in   = state_ff;
      cmd.code   = mhpq_pkg::CMD_NONE;
      valid_in   = valid_ff && !rsp_tready;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_opcode == mhpq_pkg::OP_INSERT) begin
                  if (sts.full) begin
                     cmd.code = mhpq_pkg::CMD_FULL;
                     state_in = S_RESP;
                  end else begin
                     cmd.code = mhpq_pkg::CMD_INS;
                     state_in = S_UP_RD;
                  end
               end else begin
                  if (sts.empty) begin
                     cmd.code = mhpq_pkg::CMD_EMPTY;
                     state_in = S_RESP;
                  end else begin
                     cmd.code = mhpq_pkg::CMD_RM;
                     state_in = S_RM_LD;
                  end
               end
            end
         end
         S_UP_RD: begin
            if (sts.pos_zero) begin
               cmd.code = mhpq_pkg::CMD_PUT;
               state_in = S_RESP;
            end else begin
               cmd.code = mhpq_pkg::CMD_RD_UP;
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            if (sts.up_gt) begin
               cmd.code = mhpq_pkg::CMD_UP_MOVE;
               state_in = S_UP_RD;
            end else begin
               cmd.code = mhpq_pkg::CMD_PUT;
               state_in = S_RESP;
            end
         end
         S_RM_LD: begin
            cmd.code = mhpq_pkg::CMD_RM_LOAD;
            state_in = sts.count_one ? S_RESP : S_DN_RD;
         end
         S_DN_RD: begin
            if (sts.no_left) begin
               cmd.code = mhpq_pkg::CMD_PUT;
               state_in = S_RESP;
            end else begin
               cmd.code = mhpq_pkg::CMD_RD_DN;
               state_in = S_DN_CMP;
            end
         end
         S_DN_CMP: begin
            if (sts.dn_move) begin
               cmd.code = mhpq_pkg::CMD_DN_MOVE;
               state_in = S_DN_RD;
            end else begin
               cmd.code = mhpq_pkg::CMD_PUT;
               state_in = S_RESP;
            end
         end
         S_RESP: begin
            // load the output register once it is free
            if (!valid_ff || rsp_tready) begin
               cmd.code = mhpq_pkg::CMD_OUT;
               valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

endmodule

// ===== hw/rtl/mhpq_dp.sv =====
// ----------------------------------------------------------------------------
// mhpq_dp
// Heap datapath: entry memory, hole position, held value, entry count and
// the output register. The moving value stays in a register and the hole
// walks through the memory instead of swapping slots.
// ----------------------------------------------------------------------------
module mhpq_dp #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mhpq_pkg::cmd_type                    cmd,
   input  logic        [mhpq_pkg::VALUE_W-1:0]  req_value,
   output mhpq_pkg::sts_type                    sts,
   output logic        [mhpq_pkg::STATUS_W-1:0] rsp_status,
   output logic signed [mhpq_pkg::VALUE_W-1:0]  rsp_removed,
   output logic        [mhpq_pkg::HELD_W-1:0]   rsp_held
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = AW + 2;              // child index plus headroom
   localparam int EW = CW + mhpq_pkg::HELD_W;

   // entry memory
   logic signed [mhpq_pkg::VALUE_W-1:0] heap_ff [CAPACITY];
   logic signed [mhpq_pkg::VALUE_W-1:0] rd_a_ff, rd_b_ff;
   logic        [AW-1:0]                addr_a, addr_b, wr_addr;
   logic signed [mhpq_pkg::VALUE_W-1:0] wr_data;
   logic                                wr_en;

   // working registers
   logic [AW-1:0]                        pos_ff, pos_in;
   logic [CW-1:0]                        count_ff, count_in;
   logic signed [mhpq_pkg::VALUE_W-1:0]  hold_ff, hold_in;
   logic signed [mhpq_pkg::VALUE_W-1:0]  removed_ff, removed_in;
   logic [mhpq_pkg::STATUS_W-1:0]        status_ff, status_in;

   // output register
   logic [mhpq_pkg::STATUS_W-1:0]        out_status_ff;
   logic signed [mhpq_pkg::VALUE_W-1:0]  out_removed_ff;
   logic [mhpq_pkg::HELD_W-1:0]          out_held_ff;

   // index arithmetic
   logic [AW-1:0]  parent;
   logic [XW-1:0]  left_x, right_x, count_x;
   logic [AW-1:0]  last;
   logic           left_gt, right_gt;
   logic signed [mhpq_pkg::VALUE_W-1:0] cand;
   logic [EW-1:0]  count_ext;

   assign parent  = (pos_ff - AW'(1)) >> 1;
   assign left_x  = {(XW-1)'(pos_ff), 1'b1};
   assign right_x = left_x + XW'(1);
   assign count_x = XW'(count_ff);
   assign last    = AW'(count_ff - CW'(1));
   assign count_ext = EW'(count_ff);

   // sift down compare: left wins ties, children must beat strictly
   assign left_gt  = rd_a_ff > hold_ff;
   assign cand     = left_gt ? rd_a_ff : hold_ff;
   assign right_gt = (right_x < count_x) && (rd_b_ff > cand);

   // status to the controller
   assign sts.full      = (count_ff == CW'(CAPACITY));
   assign sts.empty     = (count_ff == '0);
   assign sts.count_one = (count_ff == CW'(1));
   assign sts.pos_zero  = (pos_ff == '0);
   assign sts.no_left   = !(left_x < count_x);
   assign sts.up_gt     = hold_ff > rd_a_ff;
   assign sts.dn_move   = left_gt || right_gt;

   // command decode
   always_comb begin
      addr_a     = '0;
      addr_b     = '0;
      wr_addr    = pos_ff;
      wr_data    = hold_ff;
      wr_en      = 1'b0;
      pos_in     = pos_ff;
      count_in   = count_ff;
      hold_in    = hold_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      case (cmd.code)
         mhpq_pkg::CMD_INS: begin
            hold_in    = $signed(req_value);
            pos_in     = AW'(count_ff);
            count_in   = count_ff + CW'(1);
            status_in  = mhpq_pkg::ST_OK;
            removed_in = '0;
         end
         mhpq_pkg::CMD_FULL: begin
            status_in  = mhpq_pkg::ST_FULL;
            removed_in = '0;
         end
         mhpq_pkg::CMD_EMPTY: begin
            status_in  = mhpq_pkg::ST_EMPTY;
            removed_in = '0;
         end
         mhpq_pkg::CMD_RM: begin
            addr_a    = '0;
            addr_b    = last;
            status_in = mhpq_pkg::ST_OK;
         end
         mhpq_pkg::CMD_RM_LOAD: begin
            removed_in = rd_a_ff;
            hold_in    = rd_b_ff;
            count_in   = count_ff - CW'(1);
            pos_in     = '0;
         end
         mhpq_pkg::CMD_RD_UP: begin
            addr_a = parent;
         end
         mhpq_pkg::CMD_UP_MOVE: begin
            wr_en   = 1'b1;
            wr_data = rd_a_ff;
            pos_in  = parent;
         end
         mhpq_pkg::CMD_PUT: begin
            wr_en = 1'b1;
         end
         mhpq_pkg::CMD_RD_DN: begin
            addr_a = left_x[AW-1:0];
            addr_b = right_x[AW-1:0];
         end
         mhpq_pkg::CMD_DN_MOVE: begin
            wr_en   = 1'b1;
            wr_data = right_gt ? rd_b_ff : rd_a_ff;
            pos_in  = right_gt ? right_x[AW-1:0] : left_x[AW-1:0];
         end
         default: begin
         end
      endcase
   end

   // memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= heap_ff[addr_a];
      rd_b_ff <= heap_ff[addr_b];
   end

   // working and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      pos_ff     <= pos_in;
      hold_ff    <= hold_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
      if (cmd.code == mhpq_pkg::CMD_OUT) begin
         out_status_ff  <= status_ff;
         out_removed_ff <= removed_ff;
         out_held_ff    <= count_ext[mhpq_pkg::HELD_W-1:0];
      end
   end

   assign rsp_status  = out_status_ff;
   assign rsp_removed = out_removed_ff;
   assign rsp_held    = out_held_ff;

endmodule

// ===== hw/rtl/max_heap_priority_queue.sv =====
// Sequence: an insert climbs one level per parent read and compare/move step until it
// reaches the root or no longer beats the parent; a remove reads root and last entry,
// loads them, then sinks one level per children read and compare/move step until no
// child beats it or the hole has no left child; the last entry and refused words go
// straight to the result. One word at a time, next word taken in the cycle after the load.
// Reset: synchronous, active high; entry count to zero, memory is not cleared.
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue: insert a signed value or remove the maximum.
// ----------------------------------------------------------------------------
module max_heap_priority_queue #(
   parameter int CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] removed_value, [38:32] entries_held
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   mhpq_pkg::cmd_type cmd;
   mhpq_pkg::sts_type sts;

   logic signed [mhpq_pkg::VALUE_W-1:0] removed;
   logic        [mhpq_pkg::HELD_W-1:0]  held;

   mhpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_opcode (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   mhpq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_value   (req_tdata),
      .sts         (sts),
      .rsp_status  (rsp_tuser),
      .rsp_removed (removed),
      .rsp_held    (held)
   );

   assign rsp_tdata = {1'b0, held, removed};

`ifndef ASSERT_OFF
   // one word in flight: no new word the cycle after one is taken
   a_one_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("word taken while busy");

   // an empty answer reports no value and an empty heap
   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == mhpq_pkg::ST_EMPTY) |->
         (removed == '0) && (held == '0))
      else $error("empty answer carries data");

   // a refused insert reports no value
   a_full_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == mhpq_pkg::ST_FULL) |-> (removed == '0))
      else $error("full answer carries data");

   // the output register only loads when free or being drained
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.code == mhpq_pkg::CMD_OUT) |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten");
`endif

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the max-heap priority queue.
// A short table of directed words comes first: empty removes, extreme values
// and ties. Phases of random inserts and removes follow. Some phases push the
// heap to full and others drain it to empty. Both stream sides idle at random.
// Every result word is checked against the bench heap model or a typed expectation.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAP          = mhpq_pkg::CAPACITY_DEF;
   localparam int RANDOM_WORDS = 1850;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 1_000_000;

   typedef struct packed {
      logic [mhpq_pkg::STATUS_W-1:0]       status;
      logic signed [mhpq_pkg::VALUE_W-1:0] removed;
      logic [mhpq_pkg::HELD_W-1:0]         held;
   } outcome_type;

   typedef struct {
      logic        op;
      logic [31:0] value;
      bit          fixed;     // expectation typed into the table
      outcome_type want;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] value
   logic        req_tuser;   // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // [31:0] removed_value, [38:32] entries_held
   logic [1:0]  rsp_tuser;   // [1:0] status

   // bench copy of the heap
   logic signed [mhpq_pkg::VALUE_W-1:0] heap_img [CAP];
   int unsigned                         heap_len;

   outcome_type  awaited_results[$];
   stim_row_type directed_rows[$];
   int           mismatch_count;
   int           cycle_count;
   bit           calm;           // no idling on either side
   bit           hold_pending;   // ask the receiver for one long hold-off

   max_heap_priority_queue #(.CAPACITY(CAP)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // one insert or remove applied to the bench heap
   function automatic outcome_type predict_heap_op(input logic op,
                                 input logic signed [mhpq_pkg::VALUE_W-1:0] val);
      outcome_type                         res;
      int unsigned                         pos, up, lc, rc, big;
      logic signed [mhpq_pkg::VALUE_W-1:0] tmp;
      res.status  = mhpq_pkg::ST_OK;
      res.removed = '0;
      if (op == mhpq_pkg::OP_INSERT) begin
         if (heap_len >= CAP) begin
            res.status = mhpq_pkg::ST_FULL;
         end else begin
            heap_img[heap_len] = val;
            pos = heap_len;
            heap_len++;
            // climb while strictly greater than the parent
            while (pos > 0) begin
               up = (pos - 1) / 2;
               if (!(heap_img[pos] > heap_img[up])) break;
               tmp = heap_img[pos];
               heap_img[pos] = heap_img[up];
               heap_img[up] = tmp;
               pos = up;
            end
         end
      end else begin
         if (heap_len == 0) begin
            res.status = mhpq_pkg::ST_EMPTY;
         end else begin
            res.removed = heap_img[0];
            heap_len--;
            heap_img[0] = heap_img[heap_len];
            // sink toward the larger child, left wins a tie
            pos = 0;
            while (pos < heap_len) begin
               lc = 2 * pos + 1;
               rc = lc + 1;
               big = pos;
               if (lc < heap_len && heap_img[lc] > heap_img[big]) big = lc;
               if (rc < heap_len && heap_img[rc] > heap_img[big]) big = rc;
               if (big == pos) break;
               tmp = heap_img[pos];
               heap_img[pos] = heap_img[big];
               heap_img[big] = tmp;
               pos = big;
            end
         end
      end
      res.held = heap_len[mhpq_pkg::HELD_W-1:0];
      return res;
   endfunction

   // idle length: mostly none, some short, a few long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // values: extremes, a narrow band for ties, or anything
   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: begin
            case ($urandom_range(0, 4))
               0: return 32'h7FFF_FFFF;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               3: return 32'hFFFF_FFFF;
               default: return 32'h0000_0001;
            endcase
         end
         1, 2, 3: return 32'($signed($urandom_range(0, 16)) - 8);
         default: return $urandom;
      endcase
   endfunction

   task automatic flag_mismatch(input string msg);
      $display("%0t: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic add_row(input logic op, input logic [31:0] val, input bit fixed,
                          input logic [mhpq_pkg::STATUS_W-1:0] st,
                          input logic [31:0] rm,
                          input logic [mhpq_pkg::HELD_W-1:0] held);
      stim_row_type row;
      row.op           = op;
      row.value        = val;
      row.fixed        = fixed;
      row.want.status  = st;
      row.want.removed = rm;
      row.want.held    = held;
      directed_rows.push_back(row);
   endtask

   // offer one word, log its expectation on acceptance, then maybe idle
   task automatic send_word(input logic op, input logic [31:0] val, input bit fixed,
                            input outcome_type want);
      outcome_type pred;
      int          gap;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= val;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pred = predict_heap_op(op, val);
      awaited_results.push_back(fixed ? want : pred);
      gap = calm ? 0 : idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
   endtask

   // receiver: random stalls, calm stretches and one long hold-off
   initial begin
      int n;
      rsp_tready = 1'b0;
      forever begin
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else if (calm) begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end else begin
            n = idle_len();
            if (n > 0) begin
               rsp_tready <= 1'b0;
               repeat (n) @(posedge clock);
            end
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   // result checker
   always @(posedge clock) begin
      outcome_type                         want;
      logic [mhpq_pkg::STATUS_W-1:0]       got_st;
      logic signed [mhpq_pkg::VALUE_W-1:0] got_rm;
      logic [mhpq_pkg::HELD_W-1:0]         got_held;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_st   = rsp_tuser;
         got_rm   = rsp_tdata[31:0];
         got_held = rsp_tdata[38:32];
         if (awaited_results.size() == 0) begin
            flag_mismatch($sformatf("result word with nothing awaited: status %0d value %0d",
                                    got_st, got_rm));
         end else begin
            want = awaited_results.pop_front();
            if (got_st !== want.status)
               flag_mismatch($sformatf("status %0d, expected %0d", got_st, want.status));
            if (got_rm !== want.removed)
               flag_mismatch($sformatf("removed value %0d, expected %0d",
                                       got_rm, want.removed));
            if (got_held !== want.held)
               flag_mismatch($sformatf("entries held %0d, expected %0d",
                                       got_held, want.held));
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // stimulus
   initial begin
      outcome_type none;
      int          sent;
      int          phase;
      int          span;
      int          ins_pct;
      logic        op;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tuser      = mhpq_pkg::OP_INSERT;
      heap_len       = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      calm           = 1'b0;
      hold_pending   = 1'b0;
      none           = '0;

      // removes on empty, extremes in and out, ties, alternating bit patterns
      add_row(mhpq_pkg::OP_REMOVE, 32'h0000_0000, 1, mhpq_pkg::ST_EMPTY, 32'h0000_0000, 7'd0);
      add_row(mhpq_pkg::OP_INSERT, 32'h7FFF_FFFF, 1, mhpq_pkg::ST_OK,    32'h0000_0000, 7'd1);
      add_row(mhpq_pkg::OP_INSERT, 32'h8000_0000, 1, mhpq_pkg::ST_OK,    32'h0000_0000, 7'd2);
      add_row(mhpq_pkg::OP_INSERT, 32'h0000_0000, 1, mhpq_pkg::ST_OK,    32'h0000_0000, 7'd3);
      add_row(mhpq_pkg::OP_INSERT, 32'hFFFF_FFFF, 1, mhpq_pkg::ST_OK,    32'h0000_0000, 7'd4);
      add_row(mhpq_pkg::OP_REMOVE, 32'hFFFF_FFFF, 1, mhpq_pkg::ST_OK,    32'h7FFF_FFFF, 7'd3);
      add_row(mhpq_pkg::OP_REMOVE, 32'h0000_0000, 1, mhpq_pkg::ST_OK,    32'h0000_0000, 7'd2);
      add_row(mhpq_pkg::OP_REMOVE, 32'h1234_5678, 1, mhpq_pkg::ST_OK,    32'hFFFF_FFFF, 7'd1);
      add_row(mhpq_pkg::OP_REMOVE, 32'h0000_0000, 1, mhpq_pkg::ST_OK,    32'h8000_0000, 7'd0);
      add_row(mhpq_pkg::OP_REMOVE, 32'h7FFF_FFFF, 1, mhpq_pkg::ST_EMPTY, 32'h0000_0000, 7'd0);
      add_row(mhpq_pkg::OP_INSERT, 32'd5, 0, mhpq_pkg::ST_OK, '0, '0);
      add_row(mhpq_pkg::OP_INSERT, 32'd5, 0, mhpq_pkg::ST_OK, '0, '0);
      add_row(mhpq_pkg::OP_INSERT, 32'd7, 0, mhpq_pkg::ST_OK, '0, '0);
      add_row(mhpq_pkg::OP_INSERT, 32'd5, 0, mhpq_pkg::ST_OK, '0, '0);
      add_row(mhpq_pkg::OP_INSERT, 32'd7, 0, mhpq_pkg::ST_OK, '0, '0);
      add_row(mhpq_pkg::OP_INSERT, 32'hAAAA_AAAA, 0, mhpq_pkg::ST_OK, '0, '0);
      add_row(mhpq_pkg::OP_INSERT, 32'h5555_5555, 0, mhpq_pkg::ST_OK, '0, '0);
      repeat (8) add_row(mhpq_pkg::OP_REMOVE, 32'h0000_0000, 0, mhpq_pkg::ST_OK, '0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_word(directed_rows[i].op, directed_rows[i].value,
                   directed_rows[i].fixed, directed_rows[i].want);
      wait_drained();

      // random phases: fill to full, churn, drain to empty
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_WORDS) begin
         case (phase % 4)
            0: ins_pct = 90;
            1: ins_pct = 55;
            2: ins_pct = 45;
            default: ins_pct = 10;
         endcase
         calm = (phase % 5 == 3);
         if (phase == 2) hold_pending = 1'b1;
         span = $urandom_range(80, 200);
         if (span > RANDOM_WORDS - sent) span = RANDOM_WORDS - sent;
         repeat (span) begin
            op = ($urandom_range(0, 99) < ins_pct) ? mhpq_pkg::OP_INSERT
                                                   : mhpq_pkg::OP_REMOVE;
            send_word(op, pick_value(), 0, none);
            sent++;
         end
         calm = 1'b0;
         wait_drained();
         phase++;
      end

      // let any trailing work settle
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/mhpq_pkg.sv
hw/rtl/mhpq_ctrl.sv
hw/rtl/mhpq_dp.sv
hw/rtl/max_heap_priority_queue.sv
tb/tb.sv
